FILE: hw/rtl/udm_pkg.sv
// ----------------------------------------------------------------------------
// udm_pkg
// Shared widths, codes and control types of the unsigned magic-number
// generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package udm_pkg;

  // payload widths of the input and result words
  localparam int unsigned DIVISOR_W = 32;
  localparam int unsigned MAGIC_W   = 32;
  localparam int unsigned SHIFT_W   = 6;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_NC,
    ST_DIV_Q1,
    ST_DIV_Q2,
    ST_STEP,
    ST_CHECK,
    ST_DONE
  } state_e;

  // datapath commands
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_STEP,
    OP_START_Q1,
    OP_START_Q2,
    OP_START_LOOP,
    OP_LOOP_STEP,
    OP_WRITE_OUT
  } op_e;

  // datapath status seen by the controller
  typedef struct packed {
    logic in_zero;    // divisor on the input is zero
    logic div_done;   // shared divider has produced all quotient bits
    logic loop_more;  // doubling loop needs another iteration
    logic out_free;   // result register can take a new word
  } status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/udm_div_if.sv
// ----------------------------------------------------------------------------
// udm_div_if
// Valid/ready channel carrying one divisor word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface udm_div_if;
  import udm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [DIVISOR_W-1:0] divisor;

  modport source (output valid, output divisor, input ready);
  modport sink   (input valid, input divisor, output ready);

endinterface

`default_nettype wire

FILE: hw/rtl/udm_res_if.sv
// ----------------------------------------------------------------------------
// udm_res_if
// Valid/ready channel carrying one magic-number result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface udm_res_if;
  import udm_pkg::*;

  logic               valid;
  logic               ready;
  logic [MAGIC_W-1:0] magic;
  logic               add_needed;
  logic [SHIFT_W-1:0] shift;

  modport source (output valid, output magic, output add_needed, output shift, input ready);
  modport sink   (input valid, input magic, input add_needed, input shift, output ready);

endinterface

`default_nettype wire

FILE: hw/rtl/udm_datapath.sv
// ----------------------------------------------------------------------------
// udm_datapath
// Shared restoring divider, doubling-loop registers and result register of
// the magic-number generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module udm_datapath #(
  parameter int unsigned WORD_WIDTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire udm_pkg::op_e                  op_i,
  input  wire logic [udm_pkg::DIVISOR_W-1:0] divisor_i,
  input  wire logic                          out_ready_i,
  output udm_pkg::status_t                   status_o,
  output logic                               out_valid_o,
  output logic [udm_pkg::MAGIC_W-1:0]        magic_o,
  output logic                               add_needed_o,
  output logic [udm_pkg::SHIFT_W-1:0]        shift_o
);
  import udm_pkg::*;

  localparam int unsigned CntW = $clog2(WORD_WIDTH + 1);
  localparam int unsigned PW   = $clog2(2 * WORD_WIDTH + 1);

  localparam logic [WORD_WIDTH-1:0] Top    = {1'b1, {(WORD_WIDTH-1){1'b0}}};
  localparam logic [WORD_WIDTH-1:0] TopM1  = ~Top;
  localparam logic [CntW-1:0]       CntEnd = CntW'(WORD_WIDTH);
  localparam logic [PW-1:0]         PEnd   = PW'(2 * WORD_WIDTH);
  localparam logic [PW-1:0]         PStart = PW'(WORD_WIDTH - 1);
  localparam logic [PW-1:0]         PBase  = PW'(WORD_WIDTH);

  logic [WORD_WIDTH-1:0] d_in;

  // operand and loop registers
  logic [WORD_WIDTH-1:0] d_q, nc_q;
  logic [WORD_WIDTH-1:0] q1_q, r1_q, q2_q, r2_q;
  logic [PW-1:0]         p_q;
  logic                  add_q;

  // shared divider registers
  logic [WORD_WIDTH-1:0] rem_q, quo_q;
  logic                  div_nc_q;
  logic [CntW-1:0]       cnt_q;

  // result register
  logic                  out_valid_q;
  logic [MAGIC_W-1:0]    magic_q;
  logic                  add_out_q;
  logic [SHIFT_W-1:0]    shift_q;

  assign d_in = WORD_WIDTH'(divisor_i);

  // one restoring step: shift in the next dividend bit, subtract if it fits
  logic [WORD_WIDTH-1:0] div_by;
  logic [WORD_WIDTH:0]   rem_sh;
  logic [WORD_WIDTH+1:0] diff;
  logic                  qbit;
  logic [WORD_WIDTH-1:0] rem_n;

  always_comb begin
    div_by = div_nc_q ? nc_q : d_q;
    rem_sh = {rem_q, quo_q[WORD_WIDTH-1]};
    diff   = {1'b0, rem_sh} - {2'b00, div_by};
    qbit   = ~diff[WORD_WIDTH+1];
    rem_n  = qbit ? diff[WORD_WIDTH-1:0] : rem_sh[WORD_WIDTH-1:0];
  end

  // one doubling iteration on q1/r1 and q2/r2
  logic                  c1, c2, ovf;
  logic [WORD_WIDTH-1:0] r1_dbl, r2_dbl;
  logic [WORD_WIDTH-1:0] r1_n, r2_n;

  always_comb begin
    r1_dbl = {r1_q[WORD_WIDTH-2:0], 1'b0};
    r2_dbl = {r2_q[WORD_WIDTH-2:0], 1'b1};
    c1     = r1_q >= (nc_q - r1_q);
    c2     = (r2_q + WORD_WIDTH'(1)) >= (d_q - r2_q);
    ovf    = c2 ? (q2_q >= TopM1) : (q2_q >= Top);
    r1_n   = c1 ? (r1_dbl - nc_q) : r1_dbl;
    r2_n   = c2 ? (r2_dbl - d_q) : r2_dbl;
  end

  // exactness test on the registered loop values
  logic [WORD_WIDTH-1:0] delta;
  logic                  loop_more;

  always_comb begin
    delta     = d_q - WORD_WIDTH'(1) - r2_q;
    loop_more = (p_q < PEnd) &&
                ((q1_q < delta) || ((q1_q == delta) && (r1_q == '0)));
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD: begin
        d_q      <= d_in;
        rem_q    <= '0;
        quo_q    <= '0 - d_in;
        div_nc_q <= 1'b0;
      end
      OP_DIV_STEP: begin
        rem_q <= rem_n;
        quo_q <= {quo_q[WORD_WIDTH-2:0], qbit};
      end
      OP_START_Q1: begin
        nc_q     <= ~rem_q;
        rem_q    <= '0;
        quo_q    <= Top;
        div_nc_q <= 1'b1;
      end
      OP_START_Q2: begin
        q1_q     <= quo_q;
        r1_q     <= rem_q;
        rem_q    <= '0;
        quo_q    <= TopM1;
        div_nc_q <= 1'b0;
      end
      OP_START_LOOP: begin
        q2_q  <= quo_q;
        r2_q  <= rem_q;
        p_q   <= PStart;
        add_q <= 1'b0;
      end
      OP_LOOP_STEP: begin
        q1_q  <= {q1_q[WORD_WIDTH-2:0], c1};
        r1_q  <= r1_n;
        q2_q  <= {q2_q[WORD_WIDTH-2:0], c2};
        r2_q  <= r2_n;
        p_q   <= p_q + PW'(1);
        add_q <= add_q | ovf;
      end
      OP_WRITE_OUT: begin
        if (d_q == '0) begin
          magic_q   <= '0;
          add_out_q <= 1'b0;
          shift_q   <= '0;
        end else begin
          magic_q   <= MAGIC_W'(q2_q + WORD_WIDTH'(1));
          add_out_q <= add_q;
          shift_q   <= SHIFT_W'(p_q - PBase);
        end
      end
      default: begin
      end
    endcase
  end

  // divider step count and result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (op_i) inside
        OP_DIV_STEP: cnt_q <= cnt_q + CntW'(1);
        OP_LOAD, OP_START_Q1, OP_START_Q2: cnt_q <= '0;
        default: begin
        end
      endcase
      if (op_i == OP_WRITE_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // status back to the controller
  always_comb begin
    status_o.in_zero   = (d_in == '0);
    status_o.div_done  = (cnt_q == CntEnd);
    status_o.loop_more = loop_more;
    status_o.out_free  = ~out_valid_q | out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign magic_o      = magic_q;
  assign add_needed_o = add_out_q;
  assign shift_o      = shift_q;

endmodule

`default_nettype wire

FILE: hw/rtl/udm_ctrl.sv
// ----------------------------------------------------------------------------
// udm_ctrl
// Sequencer of the magic-number generator: runs the three setup divisions,
// the doubling loop and the hand-off to the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module udm_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire udm_pkg::status_t status_i,
  output udm_pkg::op_e          op_o
);
  import udm_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.in_zero ? ST_DONE : ST_DIV_NC;
        end
      end
      ST_DIV_NC: if (status_i.div_done) state_d = ST_DIV_Q1;
      ST_DIV_Q1: if (status_i.div_done) state_d = ST_DIV_Q2;
      ST_DIV_Q2: if (status_i.div_done) state_d = ST_STEP;
      ST_STEP:   state_d = ST_CHECK;
      ST_CHECK:  state_d = status_i.loop_more ? ST_STEP : ST_DONE;
      ST_DONE:   if (status_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    in_ready_o = 1'b0;
    op_o       = OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) op_o = OP_LOAD;
      end
      ST_DIV_NC: op_o = status_i.div_done ? OP_START_Q1 : OP_DIV_STEP;
      ST_DIV_Q1: op_o = status_i.div_done ? OP_START_Q2 : OP_DIV_STEP;
      ST_DIV_Q2: op_o = status_i.div_done ? OP_START_LOOP : OP_DIV_STEP;
      ST_STEP:   op_o = OP_LOOP_STEP;
      ST_CHECK:  op_o = OP_NONE;
      ST_DONE:   if (status_i.out_free) op_o = OP_WRITE_OUT;
      default:   op_o = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/unsigned_div_magic_number.sv
// ----------------------------------------------------------------------------
// unsigned_div_magic_number
// Magic multiplier, add flag and shift for replacing unsigned division by a
// constant divisor with a high multiply and shifts.
// ----------------------------------------------------------------------------
// Takes one divisor word at a time and returns one result word for it. With
// W = WORD_WIDTH, a nonzero divisor runs three setup divisions and then k
// doubling iterations, where k runs from 1 to W+1. The single restoring
// divider makes one quotient bit per cycle for each of the three setup
// divisions, and the doubling loop updates its registers in ST_STEP and
// runs the exactness test in ST_CHECK.
// A zero divisor returns all-zero fields and goes straight to the hand-off.
// The result sits in an output register, so a new divisor is taken while
// the previous result still waits; only a finished result that finds that
// register full holds up the block.
`timescale 1ns / 1ps
`default_nettype none

module unsigned_div_magic_number #(
  parameter int unsigned WORD_WIDTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  udm_div_if.sink   div_i,
  udm_res_if.source res_o
);
  import udm_pkg::*;

  op_e     op;
  status_t status;

  // sequencer
  udm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (div_i.valid),
    .in_ready_o (div_i.ready),
    .status_i   (status),
    .op_o       (op)
  );

  // divider, loop and result register
  udm_datapath #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (op),
    .divisor_i    (div_i.divisor),
    .out_ready_i  (res_o.ready),
    .status_o     (status),
    .out_valid_o  (res_o.valid),
    .magic_o      (res_o.magic),
    .add_needed_o (res_o.add_needed),
    .shift_o      (res_o.shift)
  );

endmodule

`default_nettype wire

FILE: dv/udm_checker.sv
// ----------------------------------------------------------------------------
// udm_checker
// Watches the divisor and result channels of the magic-number generator,
// computes the magic multiplier, add flag and shift for every accepted
// divisor word and compares each result word against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module udm_checker (
  input  logic clk_i,
  input  logic rst_ni,
  udm_div_if   div_i,
  udm_res_if   res_i,
  output int   fail_count_o,
  output int   pending_o
);
  import udm_pkg::*;

  localparam int unsigned WORD_W  = 32;
  localparam bit [63:0]   WORD_M  = (64'd1 << WORD_W) - 64'd1;
  localparam bit [63:0]   HALF_UP = 64'd1 << (WORD_W - 1);

  typedef struct {
    logic [DIVISOR_W-1:0] divisor;
    logic [MAGIC_W-1:0]   magic;
    logic                 add_needed;
    logic [SHIFT_W-1:0]   shift;
  } magic_word_t;

  magic_word_t magic_q[$];

  // magicu: setup divisions, then double until the multiplier is exact enough
  function automatic magic_word_t compute_magic(input logic [DIVISOR_W-1:0] divisor);
    bit [63:0]   d;
    bit [63:0]   nc;
    bit [63:0]   q1;
    bit [63:0]   r1;
    bit [63:0]   q2;
    bit [63:0]   r2;
    bit [63:0]   delta;
    int unsigned p;
    bit          add;
    magic_word_t res;
    res.divisor    = divisor;
    res.magic      = '0;
    res.add_needed = 1'b0;
    res.shift      = '0;
    d   = 64'(divisor) & WORD_M;
    add = 1'b0;
    // zero divisor gives all-zero fields
    if (d == 64'd0) begin
      return res;
    end
    nc = WORD_M - (((64'd0 - d) & WORD_M) % d);
    p  = WORD_W - 1;
    q1 = HALF_UP / nc;
    r1 = (HALF_UP - q1 * nc) & WORD_M;
    q2 = (HALF_UP - 64'd1) / d;
    r2 = ((HALF_UP - 64'd1) - q2 * d) & WORD_M;
    do begin
      p = p + 1;
      if (r1 >= ((nc - r1) & WORD_M)) begin
        q1 = (2 * q1 + 64'd1) & WORD_M;
        r1 = (2 * r1 - nc) & WORD_M;
      end else begin
        q1 = (2 * q1) & WORD_M;
        r1 = (2 * r1) & WORD_M;
      end
      if (((r2 + 64'd1) & WORD_M) >= ((d - r2) & WORD_M)) begin
        if (q2 >= HALF_UP - 64'd1) add = 1'b1;
        q2 = (2 * q2 + 64'd1) & WORD_M;
        r2 = (2 * r2 + 64'd1 - d) & WORD_M;
      end else begin
        if (q2 >= HALF_UP) add = 1'b1;
        q2 = (2 * q2) & WORD_M;
        r2 = (2 * r2 + 64'd1) & WORD_M;
      end
      delta = (d - 64'd1 - r2) & WORD_M;
    end while (p < 2 * WORD_W && (q1 < delta || (q1 == delta && r1 == 64'd0)));
    res.magic      = MAGIC_W'((q2 + 64'd1) & WORD_M);
    res.add_needed = add;
    res.shift      = SHIFT_W'(p - WORD_W);
    return res;
  endfunction

  // compare result words first, then record new divisor words
  always @(posedge clk_i or negedge rst_ni) begin
    magic_word_t exp_w;
    if (!rst_ni) begin
      fail_count_o <= 0;
      pending_o    <= 0;
      magic_q.delete();
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (magic_q.size() == 0) begin
          $display("%0t: unexpected result word magic %h add %b shift %0d", $time,
                   res_i.magic, res_i.add_needed, res_i.shift);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_w = magic_q.pop_front();
          if (res_i.magic !== exp_w.magic || res_i.add_needed !== exp_w.add_needed ||
              res_i.shift !== exp_w.shift) begin
            $display("%0t: divisor %h expected magic %h add %b shift %0d, got %h %b %0d",
                     $time, exp_w.divisor, exp_w.magic, exp_w.add_needed, exp_w.shift,
                     res_i.magic, res_i.add_needed, res_i.shift);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (div_i.valid && div_i.ready) begin
        magic_q.push_back(compute_magic(div_i.divisor));
      end
      pending_o <= magic_q.size();
    end
  end

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Top of the magic-number generator testbench: drives directed and random
// divisor words with random gaps, stalls the result side (once for a long
// stretch), and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import udm_pkg::*;

  localparam int NUM_RANDOM   = 630;
  localparam int IDLE_LIMIT   = 3000;
  localparam int LONG_HOLD    = 500;
  localparam int DRAIN_CYCLES = 300;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   idle_cycles = 0;
  int   results_taken;

  udm_div_if div_ch ();
  udm_res_if res_ch ();

  unsigned_div_magic_number u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .div_i  (div_ch),
    .res_o  (res_ch)
  );

  udm_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .div_i        (div_ch),
    .res_i        (res_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if ((div_ch.valid && div_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // offer one divisor word after a gap, hold it until taken
  task automatic send_divisor(input logic [DIVISOR_W-1:0] divisor, input int gap);
    if (gap > 0) begin
      div_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    div_ch.valid   <= 1'b1;
    div_ch.divisor <= divisor;
    do @(posedge clk_i); while (!(div_ch.valid && div_ch.ready));
    @(negedge clk_i);
  endtask

  // random divisor: full range, small, near powers of two, top bit set, products of two 16-bit values, zero
  function automatic logic [DIVISOR_W-1:0] random_divisor();
    logic [DIVISOR_W-1:0] d;
    int unsigned          k;
    case ($urandom_range(0, 4))
      0: d = $urandom();
      1: d = $urandom_range(1, 1000);
      2: begin
        k = $urandom_range(0, DIVISOR_W - 1);
        d = (32'd1 << k) + $urandom_range(0, 2) - 1;
      end
      3: d = 32'h8000_0000 | $urandom();
      default: d = $urandom_range(1, 65535) * $urandom_range(1, 65535);
    endcase
    if ($urandom_range(0, 49) == 0) d = '0;
    return d;
  endfunction

  // result side: random stalls, bursts without stalls, one long hold-off
  initial begin
    int  stall;
    bit  held;
    held          = 1'b0;
    results_taken = 0;
    res_ch.ready  = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = ((results_taken % 120) < 30) ? 0 : $urandom_range(0, 8);
      if (results_taken == 100 && !held) begin
        stall = LONG_HOLD;
        held  = 1'b1;
      end
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(res_ch.valid && res_ch.ready));
      results_taken++;
      @(negedge clk_i);
    end
  end

  // stimulus and verdict
  initial begin
    logic [DIVISOR_W-1:0] directed_q[$];
    int                   gap;
    div_ch.valid   = 1'b0;
    div_ch.divisor = '0;
    rst_ni         = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: zero, one, small odd and even, add-flag cases, word extremes
    directed_q = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd5, 32'd6, 32'd7, 32'd10, 32'd641,
                   32'd0, 32'h0000_FFFF, 32'h0001_0001, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h8000_0001, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFE,
                   32'hFFFF_FFFF, 32'd1};
    foreach (directed_q[i]) begin
      send_divisor(directed_q[i], (i < 10) ? 0 : $urandom_range(0, 8));
    end

    // random words, with stretches of back-to-back traffic
    for (int i = 0; i < NUM_RANDOM; i++) begin
      gap = ((i % 100) < 25) ? 0 : $urandom_range(0, 8);
      send_divisor(random_divisor(), gap);
    end
    div_ch.valid <= 1'b0;

    // drain outstanding results, then let the block settle
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
